// ----- hdl/dual_stack_shared_memory_macros.svh -----
// assertion macros shared by the dual stack design
`ifndef DUAL_STACK_SHARED_MEMORY_MACROS_SVH
`define DUAL_STACK_SHARED_MEMORY_MACROS_SVH

// checked only while out of reset
`define DSSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define DSSM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- hdl/dssm_pkg.sv -----
// shared types and constants of the dual stack block
package dssm_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int DATA_W    = 32;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_PEEK = 2'd2
  } dssm_cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } dssm_status_e;

  // controller to datapath
  typedef struct packed {
    logic accept;     // item taken this cycle
    logic load_read;  // move memory read data into the result register
  } dssm_ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic res_free;   // result register can take a value this cycle
    logic needs_read; // offered item is a pop or peek on a non-empty stack
  } dssm_stat_t;

endpackage

// ----- hdl/dssm_ctrl.sv -----
// controller state machine of the dual stack block
module dssm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dssm_pkg::dssm_stat_t stat_i,
  output dssm_pkg::dssm_ctrl_t ctrl_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE) && stat_i.res_free;

  always_comb begin
    state_d          = state_q;
    ctrl_o.accept    = 1'b0;
    ctrl_o.load_read = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && stat_i.res_free) begin
          ctrl_o.accept = 1'b1;
          if (stat_i.needs_read) begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        if (stat_i.res_free) begin
          ctrl_o.load_read = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hdl/dssm_datapath.sv -----
// stack pointers, shared memory and result register of the dual stack block
`include "dual_stack_shared_memory_macros.svh"

module dssm_datapath #(
  parameter int DEPTH = dssm_pkg::DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dssm_pkg::dssm_ctrl_t          ctrl_i,
  output dssm_pkg::dssm_stat_t          stat_o,
  input  logic [dssm_pkg::CMD_W-1:0]    cmd_i,
  input  logic                          sel_i,
  input  logic signed [dssm_pkg::DATA_W-1:0] push_value_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic signed [dssm_pkg::DATA_W-1:0] data_out_o,
  output logic [dssm_pkg::STATUS_W-1:0] status_o
);

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] TOP_CNT   = CNT_W'(DEPTH - 1);
  localparam logic [CNT_W:0]   DEPTH_SUM = (CNT_W + 1)'(DEPTH);

  logic [dssm_pkg::DATA_W-1:0] mem_q [DEPTH];
  logic [dssm_pkg::DATA_W-1:0] rdata_q;

  logic [CNT_W-1:0] low_cnt_q, low_cnt_d;
  logic [CNT_W-1:0] high_cnt_q, high_cnt_d;

  logic                             res_valid_q;
  logic [dssm_pkg::DATA_W-1:0]      res_data_q;
  logic [dssm_pkg::STATUS_W-1:0]    res_status_q;

  dssm_pkg::dssm_cmd_e cmd;
  logic             is_push, is_pop, is_rd;
  logic [CNT_W-1:0] sel_cnt;
  logic [CNT_W:0]   total;
  logic             full, empty, push_ok;
  logic [CNT_W-1:0] waddr_full, raddr_full;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [dssm_pkg::STATUS_W-1:0] imm_status;

  assign cmd     = dssm_pkg::dssm_cmd_e'(cmd_i);
  assign is_push = (cmd == dssm_pkg::CMD_PUSH);
  assign is_pop  = (cmd == dssm_pkg::CMD_POP);
  assign is_rd   = is_pop || (cmd == dssm_pkg::CMD_PEEK);
  assign sel_cnt = sel_i ? high_cnt_q : low_cnt_q;
  assign total   = {1'b0, low_cnt_q} + {1'b0, high_cnt_q};
  assign full    = (total >= DEPTH_SUM);
  assign empty   = (sel_cnt == '0);
  assign push_ok = is_push && !full;

  // low stack grows up from 0, high stack grows down from DEPTH-1
  assign waddr_full = sel_i ? (TOP_CNT - high_cnt_q) : low_cnt_q;
  assign raddr_full = sel_i ? (DEPTH_CNT - high_cnt_q) : (low_cnt_q - CNT_W'(1));
  assign waddr      = waddr_full[ADDR_W-1:0];
  assign raddr      = raddr_full[ADDR_W-1:0];

  assign stat_o.res_free   = !res_valid_q || out_ready_i;
  assign stat_o.needs_read = is_rd && !empty;

  always_comb begin
    imm_status = dssm_pkg::ST_OK;
    if (is_push && full) begin
      imm_status = dssm_pkg::ST_FULL;
    end else if (is_rd && empty) begin
      imm_status = dssm_pkg::ST_EMPTY;
    end
  end

  always_comb begin
    low_cnt_d  = low_cnt_q;
    high_cnt_d = high_cnt_q;
    if (ctrl_i.accept) begin
      if (push_ok) begin
        if (sel_i) begin
          high_cnt_d = high_cnt_q + CNT_W'(1);
        end else begin
          low_cnt_d = low_cnt_q + CNT_W'(1);
        end
      end else if (is_pop && !empty) begin
        if (sel_i) begin
          high_cnt_d = high_cnt_q - CNT_W'(1);
        end else begin
          low_cnt_d = low_cnt_q - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_cnt_q  <= '0;
      high_cnt_q <= '0;
    end else begin
      low_cnt_q  <= low_cnt_d;
      high_cnt_q <= high_cnt_d;
    end
  end

  // shared word store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept && push_ok) begin
      mem_q[waddr] <= push_value_i;
    end
    if (ctrl_i.accept && stat_o.needs_read) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (ctrl_i.load_read || (ctrl_i.accept && !stat_o.needs_read)) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_read) begin
      res_data_q   <= rdata_q;
      res_status_q <= dssm_pkg::ST_OK;
    end else if (ctrl_i.accept && !stat_o.needs_read) begin
      res_data_q   <= '0;
      res_status_q <= imm_status;
    end
  end

  assign out_valid_o = res_valid_q;
  assign data_out_o  = res_data_q;
  assign status_o    = res_status_q;

  `DSSM_ASSERT(a_no_overlap, ({1'b0, low_cnt_q} + {1'b0, high_cnt_q}) <= DEPTH_SUM, "stacks overlap")
  `DSSM_ASSERT(a_load_free, ctrl_i.load_read |-> stat_o.res_free, "read result loaded over a pending result")
  `DSSM_ASSERT(a_one_source, !(ctrl_i.accept && ctrl_i.load_read), "accept during memory read")
  `DSSM_ASSERT(a_low_pop, (ctrl_i.accept && is_pop && !sel_i && !empty) |=> (low_cnt_q == $past(low_cnt_q) - CNT_W'(1)), "low stack pop did not move its pointer")

endmodule

// ----- hdl/dual_stack_shared_memory.sv -----
// top level of the dual stack block: two stacks in one shared memory
//
//   channel   dir  tdata               tuser
//   s_axis    in   [31:0] push_value   [1:0] command, [2] stack_select
//   m_axis    out  [31:0] data_out     [1:0] status
//
// push, rejected push on a full memory, and pop or peek on an empty stack:
//   the result is ready the cycle after acceptance, with no wait state
// pop or peek on a non-empty stack: a read state, with no new item taken, waits out the
//   registered read port of the shared memory
// reset (rst_ni low, asynchronous) empties both stacks; memory contents stay
// input is taken only while the result register is empty or being drained,
//   so a stalled output side holds off further items
module dual_stack_shared_memory #(
  parameter int DEPTH = dssm_pkg::DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] push_value
  input  logic [2:0]  s_axis_tuser,   // [1:0] command, [2] stack_select
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] data_out
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  dssm_pkg::dssm_ctrl_t ctrl;
  dssm_pkg::dssm_stat_t stat;

  logic signed [dssm_pkg::DATA_W-1:0] data_out;

  // sequencer: accepts items and waits out the memory read
  dssm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // pointers, storage and result register
  dssm_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .cmd_i        (s_axis_tuser[1:0]),
    .sel_i        (s_axis_tuser[2]),
    .push_value_i (s_axis_tdata),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .data_out_o   (data_out),
    .status_o     (m_axis_tuser)
  );

  assign m_axis_tdata = data_out;

endmodule

// ----- bench/dual_stack_shared_memory_tb.sv -----
// self-checking testbench of the dual stack block: directed table, then random bursts
module dual_stack_shared_memory_tb;

  localparam int DEPTH           = dssm_pkg::DEPTH_DEF;
  localparam int RANDOM_ITEMS    = 500;
  localparam int IDLE_PCT        = 6;
  localparam int QUIET_FROM      = 300;   // items sent before the stretch with no idling
  localparam int QUIET_TO        = 400;
  localparam int HOLD_OFF_AT     = 150;   // items sent before the receiver stalls
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT  = 4000;

  // command code with no operation behind it
  localparam logic [dssm_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef enum int {
    MODE_FILL,
    MODE_DRAIN,
    MODE_MIXED
  } burst_mode_e;

  typedef struct {
    logic [dssm_pkg::CMD_W-1:0]  cmd;
    logic                        sel;
    logic [dssm_pkg::DATA_W-1:0] value;
  } stack_op_t;

  typedef struct {
    logic [dssm_pkg::DATA_W-1:0] data;
    dssm_pkg::dssm_status_e      status;
  } stack_reply_t;

  // one row of the directed part; fixed rows carry the reply typed in by hand
  typedef struct {
    logic [dssm_pkg::CMD_W-1:0]  cmd;
    logic                        sel;
    logic [dssm_pkg::DATA_W-1:0] value;
    bit                          fixed;
    logic [dssm_pkg::DATA_W-1:0] data;
    dssm_pkg::dssm_status_e      status;
  } stim_row_t;

  localparam int NUM_ROWS = 23;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;    // [31:0] push_value
  logic [2:0]  s_axis_tuser;    // [1:0] command, [2] stack_select
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;    // [31:0] data_out
  logic [1:0]  m_axis_tuser;    // [1:0] status

  // shadow copy of the block's memory and stack depths
  logic [dssm_pkg::DATA_W-1:0] shadow_store [DEPTH];
  int                low_depth;
  int                high_depth;

  stack_reply_t      replies_due [$];
  int                error_count;
  int                items_sent;
  int                stall_cycles;
  int                hold_off_left;
  bit                hold_off_done;

  stim_row_t directed_rows [NUM_ROWS] = '{
    // both stacks empty right after reset
    '{dssm_pkg::CMD_POP,  1'b0, 32'h0000_0000, 1'b1, 32'h0000_0000, dssm_pkg::ST_EMPTY},
    '{dssm_pkg::CMD_PEEK, 1'b0, 32'hffff_ffff, 1'b1, 32'h0000_0000, dssm_pkg::ST_EMPTY},
    '{dssm_pkg::CMD_POP,  1'b1, 32'h0000_0000, 1'b1, 32'h0000_0000, dssm_pkg::ST_EMPTY},
    '{dssm_pkg::CMD_PEEK, 1'b1, 32'hffff_ffff, 1'b1, 32'h0000_0000, dssm_pkg::ST_EMPTY},
    // unused command leaves everything alone
    '{CMD_UNUSED,         1'b0, 32'hffff_ffff, 1'b1, 32'h0000_0000, dssm_pkg::ST_OK},
    // extremes of the word on both stacks
    '{dssm_pkg::CMD_PUSH, 1'b0, 32'h7fff_ffff, 1'b1, 32'h0000_0000, dssm_pkg::ST_OK},
    '{dssm_pkg::CMD_PUSH, 1'b0, 32'h8000_0000, 1'b1, 32'h0000_0000, dssm_pkg::ST_OK},
    '{dssm_pkg::CMD_PUSH, 1'b1, 32'h8000_0000, 1'b1, 32'h0000_0000, dssm_pkg::ST_OK},
    '{dssm_pkg::CMD_PUSH, 1'b1, 32'hffff_ffff, 1'b1, 32'h0000_0000, dssm_pkg::ST_OK},
    '{dssm_pkg::CMD_PEEK, 1'b0, 32'h0000_0000, 1'b1, 32'h8000_0000, dssm_pkg::ST_OK},
    '{dssm_pkg::CMD_PEEK, 1'b1, 32'h0000_0000, 1'b1, 32'hffff_ffff, dssm_pkg::ST_OK},
    '{dssm_pkg::CMD_POP,  1'b0, 32'h0000_0000, 1'b1, 32'h8000_0000, dssm_pkg::ST_OK},
    '{dssm_pkg::CMD_POP,  1'b0, 32'h0000_0000, 1'b1, 32'h7fff_ffff, dssm_pkg::ST_OK},
    '{dssm_pkg::CMD_POP,  1'b0, 32'h0000_0000, 1'b1, 32'h0000_0000, dssm_pkg::ST_EMPTY},
    '{dssm_pkg::CMD_POP,  1'b1, 32'h0000_0000, 1'b1, 32'hffff_ffff, dssm_pkg::ST_OK},
    // from here on, rows with fixed clear go through the predictor
    '{dssm_pkg::CMD_PUSH, 1'b1, 32'h0000_0000, 1'b0, 32'h0000_0000, dssm_pkg::ST_OK},
    '{dssm_pkg::CMD_PEEK, 1'b1, 32'h1234_5678, 1'b0, 32'h0000_0000, dssm_pkg::ST_OK},
    '{CMD_UNUSED,         1'b1, 32'h0000_0000, 1'b1, 32'h0000_0000, dssm_pkg::ST_OK},
    '{dssm_pkg::CMD_POP,  1'b1, 32'h0000_0000, 1'b0, 32'h0000_0000, dssm_pkg::ST_OK},
    '{dssm_pkg::CMD_POP,  1'b1, 32'h0000_0000, 1'b0, 32'h0000_0000, dssm_pkg::ST_OK},
    '{dssm_pkg::CMD_PEEK, 1'b1, 32'h0000_0000, 1'b1, 32'h0000_0000, dssm_pkg::ST_EMPTY},
    '{dssm_pkg::CMD_PUSH, 1'b0, 32'ha5a5_a5a5, 1'b0, 32'h0000_0000, dssm_pkg::ST_OK},
    '{dssm_pkg::CMD_PEEK, 1'b0, 32'h0000_0000, 1'b0, 32'h0000_0000, dssm_pkg::ST_OK}
  };

  dual_stack_shared_memory #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // window in which neither side idles
  function automatic bit quiet_window();
    return items_sent >= QUIET_FROM && items_sent < QUIET_TO;
  endfunction

  // applies one command to the shadow stacks and returns the reply it gives
  function automatic stack_reply_t apply_stack_op(stack_op_t op);
    stack_reply_t reply;
    int           depth;
    int           addr;
    reply.data   = '0;
    reply.status = dssm_pkg::ST_OK;
    depth        = op.sel ? high_depth : low_depth;
    case (op.cmd)
      dssm_pkg::CMD_PUSH: begin
        if (low_depth + high_depth >= DEPTH) begin
          // full memory rejects the push whichever stack is chosen
          reply.status = dssm_pkg::ST_FULL;
        end else if (!op.sel) begin
          shadow_store[low_depth] = op.value;
          low_depth++;
        end else begin
          high_depth++;
          shadow_store[DEPTH - high_depth] = op.value;
        end
      end
      dssm_pkg::CMD_POP, dssm_pkg::CMD_PEEK: begin
        if (depth == 0) begin
          reply.status = dssm_pkg::ST_EMPTY;
        end else begin
          addr       = op.sel ? DEPTH - high_depth : low_depth - 1;
          reply.data = shadow_store[addr];
          if (op.cmd == dssm_pkg::CMD_POP) begin
            if (op.sel) high_depth--;
            else        low_depth--;
          end
        end
      end
      default: ;  // unused code: nothing changes
    endcase
    return reply;
  endfunction

  // word to push, with the extremes of the range turning up often
  function automatic logic [dssm_pkg::DATA_W-1:0] random_word();
    case ($urandom_range(0, 11))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  // fill bursts lean on push, drain bursts on pop; a few unused codes as noise
  function automatic stack_op_t random_stack_op(burst_mode_e mode);
    stack_op_t op;
    int        roll;
    int        push_pct;
    int        pop_pct;
    roll     = $urandom_range(0, 99);
    push_pct = (mode == MODE_FILL) ? 85 : (mode == MODE_DRAIN) ? 12 : 45;
    pop_pct  = (mode == MODE_FILL) ? 7  : (mode == MODE_DRAIN) ? 70 : 35;
    op.sel   = 1'($urandom_range(0, 1));
    op.value = random_word();
    if (roll < 3)                           op.cmd = CMD_UNUSED;
    else if (roll < 3 + push_pct)           op.cmd = dssm_pkg::CMD_PUSH;
    else if (roll < 3 + push_pct + pop_pct) op.cmd = dssm_pkg::CMD_POP;
    else                                    op.cmd = dssm_pkg::CMD_PEEK;
    return op;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on %s: got %h, expected %h", what, got, want);
    error_count++;
  endtask

  // offers one item from a falling edge on and returns at the falling edge
  // after its acceptance; the reply due is queued at the accepting edge
  task automatic send_stack_op(input stack_op_t op, input bit fixed,
                               input stack_reply_t fixed_reply);
    stack_reply_t reply;
    while (!quiet_window() && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= op.value;
    s_axis_tuser  <= {op.sel, op.cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    // the predictor always runs so that its state follows the block
    reply = apply_stack_op(op);
    if (fixed) reply = fixed_reply;
    replies_due.push_back(reply);
    items_sent++;
    @(negedge clk_i);
  endtask

  // stimulus and end of run
  initial begin
    stack_op_t    op;
    stack_reply_t typed;
    burst_mode_e  mode;
    int           burst_len;
    int           random_sent;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    error_count   = 0;
    items_sent    = 0;
    low_depth     = 0;
    high_depth    = 0;
    random_sent   = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part
    for (int i = 0; i < NUM_ROWS; i++) begin
      op.cmd       = directed_rows[i].cmd;
      op.sel       = directed_rows[i].sel;
      op.value     = directed_rows[i].value;
      typed.data   = directed_rows[i].data;
      typed.status = directed_rows[i].status;
      send_stack_op(op, directed_rows[i].fixed, typed);
    end

    // random bursts, long enough for fill bursts to reach a full memory
    while (random_sent < RANDOM_ITEMS) begin
      mode      = burst_mode_e'($urandom_range(0, 2));
      burst_len = $urandom_range(40, 120);
      for (int i = 0; i < burst_len && random_sent < RANDOM_ITEMS; i++) begin
        op = random_stack_op(mode);
        send_stack_op(op, 1'b0, typed);
        random_sent++;
      end
    end
    s_axis_tvalid <= 1'b0;

    // drain, then give the block time to show any stray reply
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (replies_due.size() != 0) begin
      report_mismatch("replies left over", 32'(replies_due.size()), 32'd0);
    end
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // receiver: random stalls, one long hold-off that backs up the input side
  initial begin
    m_axis_tready = 1'b0;
    hold_off_left = 0;
    hold_off_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_off_done && items_sent >= HOLD_OFF_AT) begin
        hold_off_done = 1'b1;
        hold_off_left = HOLD_OFF_CYCLES;
      end
      if (hold_off_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_off_left--;
      end else if (quiet_window()) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // reply checker: each accepted reply against the oldest one due
  always @(posedge clk_i) begin
    stack_reply_t due;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (replies_due.size() == 0) begin
        report_mismatch("reply with none due", m_axis_tdata, 32'd0);
      end else begin
        due = replies_due.pop_front();
        if (m_axis_tdata !== due.data) begin
          report_mismatch("data_out", m_axis_tdata, due.data);
        end
        if (m_axis_tuser !== due.status) begin
          report_mismatch("status", 32'(m_axis_tuser), 32'(due.status));
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/dssm_pkg.sv
hdl/dssm_ctrl.sv
hdl/dssm_datapath.sv
hdl/dual_stack_shared_memory.sv
bench/dual_stack_shared_memory_tb.sv
